// ----- design/cwr_pkg.sv -----
// Shared widths, latency, register indexes and side-band word for the
// cylindrical reflecting wall. No dependencies.
package cwr_pkg;

    localparam int WORD_BITS = 32;
    // root and quotient width, one bit more than a word
    localparam int RW        = WORD_BITS + 1;
    // squared distance and product width
    localparam int D2W       = 2 * WORD_BITS + 1;
    // radicand width, even, two bits retired per root stage
    localparam int SQW       = 2 * RW;
    // front stages, root stages, span and product, divider stages, output
    localparam int CWR_LAT   = 2 * RW + 6;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS   = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2
    } t_cfg_idx;

    // per-particle word that rides next to the arithmetic
    typedef struct packed {
        logic                             last;
        logic                             outside;
        logic                             dy_neg;
        logic                             dz_neg;
        logic                             qy_neg;
        logic                             qz_neg;
        logic [WORD_BITS-1:0]             dy_mag;
        logic [WORD_BITS-1:0]             dz_mag;
        logic [WORD_BITS-1:0]             pos_y;
        logic [WORD_BITS-1:0]             pos_z;
        logic [5:0][WORD_BITS-1:0]        vel;
    } t_side;

endpackage

// ----- design/cwr_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on cwr_pkg.
module cwr_sqrt
    import cwr_pkg::*;
(
    input  logic           i_clk,
    input  logic [SQW-1:0] i_rad,
    output logic [RW-1:0]  o_root
);

    logic [RW:0]    r_rem [RW];
    logic [RW-1:0]  r_res [RW];
    logic [SQW-1:0] r_rad [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW:0]    w_rem_in;
        logic [RW-1:0]  w_res_in;
        logic [SQW-1:0] w_rad_in;
        logic [RW+2:0]  w_sh;
        logic [RW+2:0]  w_trial;
        logic [RW+2:0]  w_diff;

        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_res_in = '0;
            assign w_rad_in = i_rad;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_res_in = r_res[k-1];
            assign w_rad_in = r_rad[k-1];
        end

        // bring down the next bit pair, try 4*res+1
        assign w_sh    = {w_rem_in, w_rad_in[SQW-1:SQW-2]};
        assign w_trial = {1'b0, w_res_in, 2'b01};
        assign w_diff  = w_sh - w_trial;

        always_ff @(posedge i_clk) begin
            if (w_sh >= w_trial) begin
                r_rem[k] <= w_diff[RW:0];
                r_res[k] <= {w_res_in[RW-2:0], 1'b1};
            end else begin
                r_rem[k] <= w_sh[RW:0];
                r_res[k] <= {w_res_in[RW-2:0], 1'b0};
            end
            r_rad[k] <= w_rad_in << 2;
        end
    end

    assign o_root = r_res[RW-1];

endmodule

// ----- design/cwr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage; the quotient
// is known to fit RW bits. Depends on cwr_pkg.
module cwr_div
    import cwr_pkg::*;
(
    input  logic           i_clk,
    input  logic [D2W-1:0] i_num,
    input  logic [RW-1:0]  i_den,
    output logic [RW-1:0]  o_quo
);

    logic [RW-1:0] r_rem [RW];
    logic [RW-1:0] r_low [RW];
    logic [RW-1:0] r_den [RW];
    logic [RW-1:0] r_quo [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW-1:0] w_rem_in;
        logic [RW-1:0] w_low_in;
        logic [RW-1:0] w_den_in;
        logic [RW-1:0] w_quo_in;
        logic [RW:0]   w_sh;
        logic [RW:0]   w_diff;

        if (k == 0) begin : g_first
            // upper part of the numerator is already below the divisor
            assign w_rem_in = {1'b0, i_num[D2W-1:RW]};
            assign w_low_in = i_num[RW-1:0];
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_low_in = r_low[k-1];
            assign w_den_in = r_den[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        assign w_sh   = {w_rem_in, w_low_in[RW-1]};
        assign w_diff = w_sh - {1'b0, w_den_in};

        always_ff @(posedge i_clk) begin
            if (w_sh >= {1'b0, w_den_in}) begin
                r_rem[k] <= w_diff[RW-1:0];
                r_quo[k] <= {w_quo_in[RW-2:0], 1'b1};
            end else begin
                r_rem[k] <= w_sh[RW-1:0];
                r_quo[k] <= {w_quo_in[RW-2:0], 1'b0};
            end
            r_low[k] <= w_low_in << 1;
            r_den[k] <= w_den_in;
        end
    end

    assign o_quo = r_quo[RW-1];

endmodule

// ----- design/cylinder_wall_reflect.sv -----
// Top level of the reflecting cylindrical wall: config registers, front
// stages, root, span/product, dividers and output. Uses cwr_pkg,
// cwr_sqrt, cwr_div.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------
//  particle  | i_start / o_busy   | i_pos_*, i_vel_*, i_est_vel_*, flags
//  result    | o_valid            | o_new_*, o_was_reflected, o_last_out
//  config    | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// One word per cycle in, one per cycle out; o_busy is high only in reset.
// The delay, CWR_LAT in cwr_pkg, comes mostly from the bit-per-stage root
// and divider pipelines.
// Reset clears the valid line and the config registers.
// The receiver cannot stall, so the pipeline always advances.
module cylinder_wall_reflect
    import cwr_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [WORD_BITS-1:0]        i_cfg_data,
    input  logic signed [WORD_BITS-1:0] i_pos_y,
    input  logic signed [WORD_BITS-1:0] i_pos_z,
    input  logic signed [WORD_BITS-1:0] i_vel_x,
    input  logic signed [WORD_BITS-1:0] i_vel_y,
    input  logic signed [WORD_BITS-1:0] i_vel_z,
    input  logic signed [WORD_BITS-1:0] i_est_vel_x,
    input  logic signed [WORD_BITS-1:0] i_est_vel_y,
    input  logic signed [WORD_BITS-1:0] i_est_vel_z,
    input  logic                        i_in_group,
    input  logic                        i_last_particle,
    output logic                        o_valid,
    output logic signed [WORD_BITS-1:0] o_new_pos_y,
    output logic signed [WORD_BITS-1:0] o_new_pos_z,
    output logic signed [WORD_BITS-1:0] o_new_vel_x,
    output logic signed [WORD_BITS-1:0] o_new_vel_y,
    output logic signed [WORD_BITS-1:0] o_new_vel_z,
    output logic signed [WORD_BITS-1:0] o_new_est_vel_x,
    output logic signed [WORD_BITS-1:0] o_new_est_vel_y,
    output logic signed [WORD_BITS-1:0] o_new_est_vel_z,
    output logic                        o_was_reflected,
    output logic                        o_last_out
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * WORD_BITS;

    // saturate a W+3 bit sum into a word
    function automatic logic [W-1:0] f_sat(input logic [W+2:0] v);
        logic [3:0] top;
        top = v[W+2:W-1];
        if (top == 4'b0000 || top == 4'b1111) return v[W-1:0];
        else if (v[W+2]) return {1'b1, {(W-1){1'b0}}};
        else return {1'b0, {(W-1){1'b1}}};
    endfunction

    // negate, most negative goes to most positive
    function automatic logic [W-1:0] f_neg(input logic [W-1:0] v);
        if (v == {1'b1, {(W-1){1'b0}}}) return {1'b0, {(W-1){1'b1}}};
        else return ~v + 1'b1;
    endfunction

    // center plus signed quotient, saturated
    function automatic logic [W-1:0] f_mirror(input logic [W-1:0] c,
                                              input logic [RW-1:0] q,
                                              input logic neg);
        logic [W+2:0] qs;
        logic [W+2:0] cs;
        qs = {3'b000, q[W-1:0]} | {2'b00, q[RW-1], {W{1'b0}}};
        if (neg) qs = ~qs + 1'b1;
        cs = {{3{c[W-1]}}, c};
        return f_sat(cs + qs);
    endfunction

    // ---------------- config registers
    logic [W-2:0] r_radius;
    logic [W-1:0] r_cy;
    logic [W-1:0] r_cz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= '0;
            r_cy     <= '0;
            r_cz     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RADIUS:   r_radius <= i_cfg_data[W-2:0];
                CFG_CENTER_Y: r_cy     <= i_cfg_data;
                CFG_CENTER_Z: r_cz     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // no word is taken while reset clears the valid line
    assign o_busy = ~i_rst_n;

    // ---------------- valid line
    logic [CWR_LAT-1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CWR_LAT-2:0], i_start & ~o_busy};
        end
    end

    // ---------------- stage 1: offsets from the axis
    logic [W:0] w_dy, w_dz, w_dy_abs, w_dz_abs;
    t_side      n_s1, r_s1;

    assign w_dy     = {i_pos_y[W-1], i_pos_y} - {r_cy[W-1], r_cy};
    assign w_dz     = {i_pos_z[W-1], i_pos_z} - {r_cz[W-1], r_cz};
    assign w_dy_abs = w_dy[W] ? ~w_dy + 1'b1 : w_dy;
    assign w_dz_abs = w_dz[W] ? ~w_dz + 1'b1 : w_dz;

    always_comb begin
        n_s1         = '0;
        n_s1.last    = i_last_particle;
        n_s1.outside = i_in_group;
        n_s1.dy_neg  = w_dy[W];
        n_s1.dz_neg  = w_dz[W];
        n_s1.dy_mag  = w_dy_abs[W-1:0];
        n_s1.dz_mag  = w_dz_abs[W-1:0];
        n_s1.pos_y   = i_pos_y;
        n_s1.pos_z   = i_pos_z;
        n_s1.vel     = {i_est_vel_z, i_est_vel_y, i_est_vel_x,
                        i_vel_z, i_vel_y, i_vel_x};
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    // ---------------- stage 2: squares
    logic [PW-1:0] r_sqy, r_sqz;
    logic [PW-3:0] r_rr;
    t_side         r_s2;

    always_ff @(posedge i_clk) begin
        r_sqy <= PW'(r_s1.dy_mag) * PW'(r_s1.dy_mag);
        r_sqz <= PW'(r_s1.dz_mag) * PW'(r_s1.dz_mag);
        r_rr  <= (PW-2)'(r_radius) * (PW-2)'(r_radius);
        r_s2  <= r_s1;
    end

    // ---------------- stage 3: distance squared and wall test
    logic [D2W-1:0] w_d2, r_d2;
    t_side          n_s3, r_s3;

    assign w_d2 = {1'b0, r_sqy} + {1'b0, r_sqz};

    always_comb begin
        n_s3         = r_s2;
        n_s3.outside = r_s2.outside & (w_d2 > D2W'(r_rr));
    end

    always_ff @(posedge i_clk) begin
        r_d2 <= w_d2;
        r_s3 <= n_s3;
    end

    // ---------------- root
    logic [RW-1:0] w_root;
    t_side         r_dl1 [RW];

    cwr_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (SQW'(r_d2)),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        r_dl1[0] <= r_s3;
        for (int k = 1; k < RW; k++) begin
            r_dl1[k] <= r_dl1[k-1];
        end
    end

    // ---------------- stage 4: span = 2R - r
    logic [RW:0]   w_span, w_span_abs;
    logic [RW-1:0] r_span_mag, r_root4, r_root5;
    logic          r_span_neg;
    t_side         r_s4, n_s5, r_s5;

    assign w_span     = {2'b00, r_radius, 1'b0} - {1'b0, w_root};
    assign w_span_abs = w_span[RW] ? ~w_span + 1'b1 : w_span;

    always_ff @(posedge i_clk) begin
        r_span_mag <= w_span_abs[RW-1:0];
        r_span_neg <= w_span[RW];
        r_root4    <= w_root;
        r_s4       <= r_dl1[RW-1];
    end

    // ---------------- stage 5: span times offset
    logic [D2W-1:0] r_prod_y, r_prod_z;

    always_comb begin
        n_s5        = r_s4;
        n_s5.qy_neg = r_span_neg ^ r_s4.dy_neg;
        n_s5.qz_neg = r_span_neg ^ r_s4.dz_neg;
    end

    always_ff @(posedge i_clk) begin
        r_prod_y <= D2W'(r_span_mag) * D2W'(r_s4.dy_mag);
        r_prod_z <= D2W'(r_span_mag) * D2W'(r_s4.dz_mag);
        r_root5  <= r_root4;
        r_s5     <= n_s5;
    end

    // ---------------- dividers
    logic [RW-1:0] w_qy, w_qz;
    t_side         r_dl2 [RW];
    t_side         w_so;

    cwr_div u_div_y (
        .i_clk (i_clk),
        .i_num (r_prod_y),
        .i_den (r_root5),
        .o_quo (w_qy)
    );

    cwr_div u_div_z (
        .i_clk (i_clk),
        .i_num (r_prod_z),
        .i_den (r_root5),
        .o_quo (w_qz)
    );

    always_ff @(posedge i_clk) begin
        r_dl2[0] <= r_s5;
        for (int k = 1; k < RW; k++) begin
            r_dl2[k] <= r_dl2[k-1];
        end
    end

    assign w_so = r_dl2[RW-1];

    // ---------------- output stage
    always_ff @(posedge i_clk) begin
        if (w_so.outside) begin
            o_new_pos_y     <= f_mirror(r_cy, w_qy, w_so.qy_neg);
            o_new_pos_z     <= f_mirror(r_cz, w_qz, w_so.qz_neg);
            o_new_vel_x     <= f_neg(w_so.vel[0]);
            o_new_vel_y     <= f_neg(w_so.vel[1]);
            o_new_vel_z     <= f_neg(w_so.vel[2]);
            o_new_est_vel_x <= f_neg(w_so.vel[3]);
            o_new_est_vel_y <= f_neg(w_so.vel[4]);
            o_new_est_vel_z <= f_neg(w_so.vel[5]);
        end else begin
            o_new_pos_y     <= w_so.pos_y;
            o_new_pos_z     <= w_so.pos_z;
            o_new_vel_x     <= w_so.vel[0];
            o_new_vel_y     <= w_so.vel[1];
            o_new_vel_z     <= w_so.vel[2];
            o_new_est_vel_x <= w_so.vel[3];
            o_new_est_vel_y <= w_so.vel[4];
            o_new_est_vel_z <= w_so.vel[5];
        end
        o_was_reflected <= w_so.outside;
        o_last_out      <= w_so.last;
    end

    assign o_valid = r_vld[CWR_LAT-1];

endmodule

// ----- design/cwr_check.sv -----
// Port-level checks on the reflecting wall, bound to the top level.
// Depends on cwr_pkg.
module cwr_check
    import cwr_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_start,
    input logic                 o_busy,
    input logic                 o_valid,
    input logic [WORD_BITS-1:0] i_vel_x,
    input logic [WORD_BITS-1:0] o_new_vel_x,
    input logic                 i_in_group,
    input logic                 i_last_particle,
    input logic                 o_was_reflected,
    input logic                 o_last_out
);

    // every accepted word comes out after the fixed latency
    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##CWR_LAT o_valid)
        else $error("accepted word did not come out");

    // no word out without an accepted start before it
    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy, CWR_LAT))
        else $error("result without a start");

    // passed-through words keep their x velocity
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_was_reflected) |-> o_new_vel_x == $past(i_vel_x, CWR_LAT))
        else $error("passed word changed");

    // only group members get mirrored
    a_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_was_reflected) |-> $past(i_in_group, CWR_LAT))
        else $error("reflection outside the group");

    // last flag stays with its word
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_last_out == $past(i_last_particle, CWR_LAT))
        else $error("last flag out of place");

endmodule

bind cylinder_wall_reflect cwr_check u_cwr_check (.*);
